/* sv/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and the ordering function shared by the priority queue files.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int OCC_W = 4;

   localparam logic       CMD_INSERT   = 1'b0;
   localparam logic       CMD_REMOVE   = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [15:0] tag;
      logic [7:0]  prio;
      logic [15:0] stamp;
   } entry_type;

   typedef struct packed {
      logic        command;
      logic [15:0] job_tag;
      logic [7:0]  priority_req;
      logic [15:0] arrival_order;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [15:0]      out_job_tag;
      logic [7:0]       out_priority;
      logic [15:0]      out_order;
      logic [OCC_W-1:0] occupancy;
   } rsp_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_INS_CMP,
      SEQ_INS_PUT,
      SEQ_REM_HEAD,
      SEQ_REM_SHIFT,
      SEQ_FINISH
   } seq_state_type;

   // a is served strictly before b
   function automatic logic entry_before(input entry_type a, input entry_type b);
      logic result;
      if (a.prio != b.prio) begin
         result = (a.prio < b.prio);
      end else begin
         result = (a.stamp < b.stamp);
      end
      return result;
   endfunction

endpackage

/* sv/spq_if.sv */
// ----------------------------------------------------------------------------
// spq_if
// Request and response channels of the priority queue (valid/ready).
// ----------------------------------------------------------------------------
interface spq_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [15:0] job_tag;
   logic [7:0]  priority_req;
   logic [15:0] arrival_order;

   modport source (output valid, command, job_tag, priority_req, arrival_order,
                   input ready);
   modport sink   (input valid, command, job_tag, priority_req, arrival_order,
                   output ready);
endinterface

interface spq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] out_job_tag;
   logic [7:0]  out_priority;
   logic [15:0] out_order;
   logic [3:0]  occupancy;

   modport source (output valid, status, out_job_tag, out_priority, out_order,
                   occupancy, input ready);
   modport sink   (input valid, status, out_job_tag, out_priority, out_order,
                   occupancy, output ready);
endinterface

/* sv/spq_store.sv */
// ----------------------------------------------------------------------------
// spq_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_store #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic                clock,
   input  logic                we,
   input  logic [AW-1:0]       waddr,
   input  spq_pkg::entry_type  wdata,
   input  logic [AW-1:0]       raddr,
   output spq_pkg::entry_type  rdata
);
   import spq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/spq_seq.sv */
// ----------------------------------------------------------------------------
// spq_seq
// Sequencer: insertion walk and removal shift over the entry memory, one
// entry per cycle through a single compare unit.
// ----------------------------------------------------------------------------
module spq_seq #(
   parameter int DEPTH = 8,
   parameter int AW    = 3,
   parameter int CW    = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  spq_pkg::req_type   req_data,
   input  logic               rsp_free,
   output logic               res_load,
   output spq_pkg::rsp_type   res_data,
   output logic               mem_we,
   output logic [AW-1:0]      mem_waddr,
   output spq_pkg::entry_type mem_wdata,
   output logic [AW-1:0]      mem_raddr,
   input  spq_pkg::entry_type mem_rdata
);
   import spq_pkg::*;

   seq_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] pos_ff, pos_in;
   entry_type     new_ff, new_in;
   entry_type     head_ff, head_in;
   logic [1:0]    status_ff, status_in;

   logic is_before;
   logic is_full;
   logic is_empty;
   logic shift_last;

   assign is_before  = entry_before(new_ff, mem_rdata);
   assign is_full    = (count_ff >= CW'(DEPTH));
   assign is_empty   = (count_ff == '0);
   assign shift_last = ((CW'(pos_ff) + CW'(1)) >= count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               if (req_data.command == CMD_INSERT) begin
                  if (is_full) begin
                     state_in = SEQ_FINISH;
                  end else if (is_empty) begin
                     state_in = SEQ_INS_PUT;
                  end else begin
                     state_in = SEQ_INS_CMP;
                  end
               end else begin
                  if (is_empty) begin
                     state_in = SEQ_FINISH;
                  end else begin
                     state_in = SEQ_REM_HEAD;
                  end
               end
            end
         end
         SEQ_INS_CMP: begin
            if (!is_before) begin
               state_in = SEQ_FINISH;
            end else if (pos_ff == AW'(1)) begin
               state_in = SEQ_INS_PUT;
            end
         end
         SEQ_INS_PUT: begin
            state_in = SEQ_FINISH;
         end
         SEQ_REM_HEAD: begin
            if (count_ff == CW'(1)) begin
               state_in = SEQ_FINISH;
            end else begin
               state_in = SEQ_REM_SHIFT;
            end
         end
         SEQ_REM_SHIFT: begin
            if (shift_last) begin
               state_in = SEQ_FINISH;
            end
         end
         SEQ_FINISH: begin
            if (rsp_free) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready = 1'b0;
      res_load  = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = pos_ff;
      mem_wdata = new_ff;
      mem_raddr = '0;
      count_in  = count_ff;
      pos_in    = pos_ff;
      new_in    = new_ff;
      head_in   = head_ff;
      status_in = status_ff;
      case (state_ff)
         SEQ_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               new_in.tag   = req_data.job_tag;
               new_in.prio  = req_data.priority_req;
               new_in.stamp = req_data.arrival_order;
               head_in      = '0;
               status_in    = STATUS_OK;
               if (req_data.command == CMD_INSERT) begin
                  if (is_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     pos_in    = count_ff[AW-1:0];
                     mem_raddr = count_ff[AW-1:0] - AW'(1);
                  end
               end else begin
                  if (is_empty) begin
                     status_in = STATUS_EMPTY;
                  end
               end
            end
         end
         SEQ_INS_CMP: begin
            mem_we = 1'b1;
            if (is_before) begin
               mem_wdata = mem_rdata;
               pos_in    = pos_ff - AW'(1);
               mem_raddr = pos_ff - AW'(2);
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         SEQ_INS_PUT: begin
            mem_we   = 1'b1;
            count_in = count_ff + CW'(1);
         end
         SEQ_REM_HEAD: begin
            head_in   = mem_rdata;
            pos_in    = AW'(1);
            mem_raddr = AW'(1);
            if (count_ff == CW'(1)) begin
               count_in = '0;
            end
         end
         SEQ_REM_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff - AW'(1);
            mem_wdata = mem_rdata;
            pos_in    = pos_ff + AW'(1);
            mem_raddr = pos_ff + AW'(1);
            if (shift_last) begin
               count_in = count_ff - CW'(1);
            end
         end
         SEQ_FINISH: begin
            res_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   assign res_data.status       = status_ff;
   assign res_data.out_job_tag  = head_ff.tag;
   assign res_data.out_priority = head_ff.prio;
   assign res_data.out_order    = head_ff.stamp;
   assign res_data.occupancy    = OCC_W'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      new_ff    <= new_in;
      head_ff   <= head_in;
      status_ff <= status_in;
   end

endmodule

/* sv/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept as a sorted array; FIFO order among ties.
// ----------------------------------------------------------------------------
// Each request item is an insert or a remove and yields one response item.
// Entries sit sorted in a single-port-read memory, lowest priority number
// first, equal priorities by order stamp. An insert walks from the tail,
// comparing the new entry with one stored entry per cycle and moving it back
// a slot; a remove reads the head and moves the rest up one per cycle. The
// memory read port sets that one-entry-per-cycle pace. Full and empty
// requests skip the memory walk. The response sits in an output register,
// so the next request may start while a response waits to be taken.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
   parameter int DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   spq_req_if.sink    req_chan,
   spq_rsp_if.source  rsp_chan
);
   import spq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   req_type       req_data;
   rsp_type       res_data;
   logic          res_load;
   logic          rsp_free;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;
   entry_type     mem_wdata;
   entry_type     mem_rdata;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign req_data.command       = req_chan.command;
   assign req_data.job_tag       = req_chan.job_tag;
   assign req_data.priority_req  = req_chan.priority_req;
   assign req_data.arrival_order = req_chan.arrival_order;

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   spq_seq #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_data  (req_data),
      .rsp_free  (rsp_free),
      .res_load  (res_load),
      .res_data  (res_data),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   spq_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_data_ff.status;
   assign rsp_chan.out_job_tag  = rsp_data_ff.out_job_tag;
   assign rsp_chan.out_priority = rsp_data_ff.out_priority;
   assign rsp_chan.out_order    = rsp_data_ff.out_order;
   assign rsp_chan.occupancy    = rsp_data_ff.occupancy;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request taken while sequencer busy");

   a_full_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == STATUS_FULL
      |-> rsp_chan.occupancy == OCC_W'(DEPTH) && rsp_chan.out_job_tag == '0)
      else $error("full response with wrong occupancy or data");

   a_empty_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == STATUS_EMPTY
      |-> rsp_chan.occupancy == '0 && rsp_chan.out_priority == '0)
      else $error("empty response with entries or data");
`endif

endmodule

/* dv/tb_sorted_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking bench for the sorted priority queue.
// ----------------------------------------------------------------------------
// Drives insert and remove items through the request channel and keeps its
// own sorted copy of the queue to predict every response item: status,
// removed entry and occupancy. A directed pass covers field extremes, remove
// on empty, insert on full and entries with identical keys. Random segments
// then lean toward inserts or removes so that the queue keeps running full
// and empty, mostly with narrow keys to force ties. The sender works in
// bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH  = 8;
   localparam int RANDOM_ITEMS = 1350;
   localparam int SEGMENT_LEN  = 50;

   class pq_scoreboard;
      entry_type   slots[QUEUE_DEPTH];
      int unsigned held;
      rsp_type     pending_rsp[$];
      int unsigned error_count;

      function new();
         held        = 0;
         error_count = 0;
      endfunction

      function void note_request(req_type r);
         rsp_type     exp;
         entry_type   e;
         int unsigned pos;
         exp = '0;
         if (r.command == CMD_INSERT) begin
            if (held >= QUEUE_DEPTH) begin
               exp.status = STATUS_FULL;
            end else begin
               e.tag   = r.job_tag;
               e.prio  = r.priority_req;
               e.stamp = r.arrival_order;
               pos     = held;
               while (pos > 0 && (e.prio < slots[pos-1].prio ||
                      (e.prio == slots[pos-1].prio && e.stamp < slots[pos-1].stamp))) begin
                  slots[pos] = slots[pos-1];
                  pos--;
               end
               slots[pos] = e;
               held++;
               exp.status = STATUS_OK;
            end
         end else begin
            if (held == 0) begin
               exp.status = STATUS_EMPTY;
            end else begin
               exp.status       = STATUS_OK;
               exp.out_job_tag  = slots[0].tag;
               exp.out_priority = slots[0].prio;
               exp.out_order    = slots[0].stamp;
               for (int k = 1; k < held; k++) slots[k-1] = slots[k];
               held--;
            end
         end
         exp.occupancy = OCC_W'(held);
         pending_rsp.push_back(exp);
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp;
         if (pending_rsp.size() == 0) begin
            $error("response item with no expectation waiting");
            error_count++;
            return;
         end
         exp = pending_rsp.pop_front();
         if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            error_count++;
         end
         if (got.out_job_tag !== exp.out_job_tag) begin
            $error("out_job_tag: expected %0h, got %0h", exp.out_job_tag, got.out_job_tag);
            error_count++;
         end
         if (got.out_priority !== exp.out_priority) begin
            $error("out_priority: expected %0d, got %0d", exp.out_priority,
                   got.out_priority);
            error_count++;
         end
         if (got.out_order !== exp.out_order) begin
            $error("out_order: expected %0h, got %0h", exp.out_order, got.out_order);
            error_count++;
         end
         if (got.occupancy !== exp.occupancy) begin
            $error("occupancy: expected %0d, got %0d", exp.occupancy, got.occupancy);
            error_count++;
         end
      endfunction

      function int unsigned outstanding();
         return pending_rsp.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   spq_req_if req_chan();
   spq_rsp_if rsp_chan();

   sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pq_scoreboard sb = new();

   int unsigned burst_left;
   int unsigned gap_max;
   int unsigned stall_mode;
   int unsigned rx_cycle;

   always #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   // receiver stall pattern in one of four randomly drawn modes
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rx_cycle       <= 0;
         stall_mode     <= 0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle % 100 == 99) stall_mode <= $urandom_range(3, 0);
         case (stall_mode)
            0: begin
               rsp_chan.ready <= 1'b1;
            end
            1: begin
               rsp_chan.ready <= 1'($urandom_range(1, 0));
            end
            2: begin
               rsp_chan.ready <= (rx_cycle[2:0] == 3'd0);
            end
            default: begin
               rsp_chan.ready <= rx_cycle[4];
            end
         endcase
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.status       = rsp_chan.status;
         got.out_job_tag  = rsp_chan.out_job_tag;
         got.out_priority = rsp_chan.out_priority;
         got.out_order    = rsp_chan.out_order;
         got.occupancy    = rsp_chan.occupancy;
         sb.check_response(got);
      end
   end

   function automatic req_type mk_item(logic cmd, logic [15:0] tag, logic [7:0] prio,
                                       logic [15:0] stamp);
      req_type r;
      r.command       = cmd;
      r.job_tag       = tag;
      r.priority_req  = prio;
      r.arrival_order = stamp;
      return r;
   endfunction

   function automatic req_type random_item(int unsigned insert_pct, bit narrow_keys);
      req_type r;
      r.command       = ($urandom_range(99, 0) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
      r.job_tag       = 16'($urandom);
      r.priority_req  = 8'($urandom);
      r.arrival_order = 16'($urandom);
      if (r.command == CMD_INSERT && narrow_keys) begin
         r.priority_req  = 8'($urandom_range(3, 0));
         r.arrival_order = 16'($urandom_range(3, 0));
      end
      return r;
   endfunction

   task automatic send_item(req_type r);
      req_chan.valid         <= 1'b1;
      req_chan.command       <= r.command;
      req_chan.job_tag       <= r.job_tag;
      req_chan.priority_req  <= r.priority_req;
      req_chan.arrival_order <= r.arrival_order;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_request(r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         if (gap_max > 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(gap_max, 1)) @(posedge clock);
         end
         burst_left = $urandom_range(40, 1);
         gap_max    = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      end
   endtask

   task automatic drain_queue();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned insert_pct;
      bit          narrow;
      clock                  = 1'b0;
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.command       = CMD_INSERT;
      req_chan.job_tag       = '0;
      req_chan.priority_req  = '0;
      req_chan.arrival_order = '0;
      burst_left             = 4;
      gap_max                = 3;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // remove on empty with all-ones payload, which a remove ignores
      send_item(mk_item(CMD_REMOVE, 16'hFFFF, 8'hFF, 16'hFFFF));
      send_item(mk_item(CMD_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF));
      send_item(mk_item(CMD_INSERT, 16'h0000, 8'h00, 16'h0000));
      // identical keys go behind each other in arrival order
      for (int i = 0; i < 6; i++) begin
         send_item(mk_item(CMD_INSERT, 16'(16'hA000 + i), 8'd5, 16'd7));
      end
      send_item(mk_item(CMD_INSERT, 16'h1234, 8'h00, 16'h0000));
      for (int i = 0; i < 9; i++) begin
         send_item(mk_item(CMD_REMOVE, 16'h5A5A, 8'hA5, 16'hC3C3));
      end
      send_item(mk_item(CMD_INSERT, 16'h0F0F, 8'h00, 16'hFFFF));
      send_item(mk_item(CMD_INSERT, 16'hF0F0, 8'h00, 16'h0000));
      send_item(mk_item(CMD_REMOVE, 16'h0000, 8'h00, 16'h0000));
      send_item(mk_item(CMD_REMOVE, 16'h0000, 8'h00, 16'h0000));
      drain_queue();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % SEGMENT_LEN == 0) begin
            case ($urandom_range(3, 0))
               0: insert_pct = 85;
               1: insert_pct = 20;
               2: insert_pct = 50;
               default: insert_pct = 60;
            endcase
            narrow = ($urandom_range(3, 0) != 0);
         end
         if (n == RANDOM_ITEMS / 2) drain_queue();
         send_item(random_item(insert_pct, narrow));
      end
      req_chan.valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.error_count == 0 && sb.outstanding() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
